// ===== rtl/est_pkg.sv =====
// entity slot table package: sizes, operation codes and shared types
// used by est_slot_mem, est_seq, entity_slot_table and est_chk; no dependencies
package est_pkg;

	localparam int SLOTS   = 64;
	localparam int ID_BITS = 16;
	localparam int TILE_W  = 8;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [TILE_W-1:0]  x;
		logic [TILE_W-1:0]  y;
	} slot_word_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		slot_word_t        wdata;
		logic [SLOT_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== rtl/est_slot_mem.sv =====
// slot memory: id and tile position of every slot, one write and one read port
// depends on est_pkg; read data is registered
module est_slot_mem
	import est_pkg::*;
(
	input  logic       clk,
	input  mem_req_t   req,
	output slot_word_t rdata
);

	slot_word_t mem_q [SLOTS];
	slot_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/est_seq.sv =====
// sequencer: holds live flags, live count and id cursor, scans slots one a cycle
// through a single shared slot compare; depends on est_pkg and drives est_slot_mem
module est_seq
	import est_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [KIND_W-1:0]  kind,
	input  logic [TILE_W-1:0]  tile_x,
	input  logic [TILE_W-1:0]  tile_y,
	input  logic [ID_BITS-1:0] entry_id,
	output logic               busy,
	output logic               done,
	output logic               ok,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [ID_BITS-1:0] given_id,
	output logic [CNT_W-1:0]   live_count,
	output mem_req_t           mem_req,
	input  slot_word_t         mem_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [SLOTS-1:0]   live_q;
	logic [CNT_W-1:0]   live_total_q;
	logic [ID_BITS-1:0] next_id_q;
	logic [KIND_W-1:0]  kind_q;
	logic [TILE_W-1:0]  x_q;
	logic [TILE_W-1:0]  y_q;
	logic [ID_BITS-1:0] eid_q;
	logic [CNT_W-1:0]   scan_q;
	logic               v_s1;
	logic [SLOT_W-1:0]  idx_s1;
	logic               done_q;
	logic               ok_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ID_BITS-1:0] gid_q;
	logic [CNT_W-1:0]   count_q;

	logic               is_pop;
	logic               is_alloc;
	logic               full;
	logic               hit;
	logic               scan_end;
	logic [ID_BITS-1:0] new_id;
	logic [ID_BITS-1:0] after_id;

	assign is_pop   = (kind_q == KIND_POP);
	assign is_alloc = (kind_q == KIND_CREATE) || (kind_q == KIND_PUSH);
	assign full     = (live_total_q >= CNT_W'(SLOTS));
	assign scan_end = (scan_q == CNT_W'(SLOTS));
	assign after_id = eid_q + ID_BITS'(1);
	assign new_id   = (kind_q == KIND_CREATE) ? next_id_q : eid_q;

	// shared slot compare: free slot for alloc, live slot with matching id for pop
	assign hit = is_pop ? (live_q[idx_s1] && (mem_rdata.id == eid_q)) : !live_q[idx_s1];

	always_comb begin
		mem_req.we       = (state_q == ST_SCAN) && v_s1 && hit && is_alloc;
		mem_req.waddr    = idx_s1;
		mem_req.wdata.id = new_id;
		mem_req.wdata.x  = x_q;
		mem_req.wdata.y  = y_q;
		mem_req.raddr    = scan_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			live_q       <= '0;
			live_total_q <= '0;
			next_id_q    <= '0;
			kind_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			eid_q        <= '0;
			scan_q       <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			done_q       <= 1'b0;
			ok_q         <= 1'b0;
			slot_q       <= '0;
			gid_q        <= '0;
			count_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						x_q     <= tile_x;
						y_q     <= tile_y;
						eid_q   <= entry_id;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (is_pop || (is_alloc && !full)) begin
						scan_q  <= '0;
						v_s1    <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						// unused kind or table full
						done_q  <= 1'b1;
						ok_q    <= 1'b0;
						slot_q  <= '0;
						gid_q   <= '0;
						count_q <= live_total_q;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					v_s1   <= !scan_end;
					idx_s1 <= scan_q[SLOT_W-1:0];
					if (!scan_end) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (v_s1 && hit) begin
						done_q  <= 1'b1;
						ok_q    <= 1'b1;
						slot_q  <= idx_s1;
						v_s1    <= 1'b0;
						state_q <= ST_IDLE;
						if (is_pop) begin
							live_q[idx_s1] <= 1'b0;
							live_total_q   <= live_total_q - CNT_W'(1);
							count_q        <= live_total_q - CNT_W'(1);
							gid_q          <= '0;
						end else begin
							live_q[idx_s1] <= 1'b1;
							live_total_q   <= live_total_q + CNT_W'(1);
							count_q        <= live_total_q + CNT_W'(1);
							gid_q          <= new_id;
							if (kind_q == KIND_CREATE) begin
								next_id_q <= next_id_q + ID_BITS'(1);
							end else if (after_id > next_id_q) begin
								next_id_q <= after_id;
							end
						end
					end else if (v_s1 && (idx_s1 == SLOT_W'(SLOTS - 1))) begin
						// last slot compared without a hit
						done_q  <= 1'b1;
						ok_q    <= 1'b0;
						slot_q  <= '0;
						gid_q   <= '0;
						count_q <= live_total_q;
						v_s1    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign ok         = ok_q;
	assign slot_index = slot_q;
	assign given_id   = gid_q;
	assign live_count = count_q;

endmodule

// ===== rtl/entity_slot_table.sv =====
// Entity slot table. A command is taken at a clock edge where start is high and
// busy is low; exactly one result beat follows, shown for one cycle with done high,
// and it cannot be held off, so the receiver must take it in that cycle. busy is
// low again in the done cycle, so the next command may be taken at its end. A
// command fails at once from the check state (unused kind, table full); otherwise
// it ends at the first matching slot or after the last slot without a hit: the sequencer
// compares one slot per cycle through the registered read port of the slot memory.
// depends on est_pkg, est_seq and est_slot_mem
module entity_slot_table
	import est_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [KIND_W-1:0]  kind,
	input  logic [TILE_W-1:0]  tile_x,
	input  logic [TILE_W-1:0]  tile_y,
	input  logic [ID_BITS-1:0] entry_id,
	output logic               done,
	output logic               ok,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [ID_BITS-1:0] given_id,
	output logic [CNT_W-1:0]   live_count
);

	mem_req_t   mem_req;
	slot_word_t mem_rdata;

	est_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.entry_id   (entry_id),
		.busy       (busy),
		.done       (done),
		.ok         (ok),
		.slot_index (slot_index),
		.given_id   (given_id),
		.live_count (live_count),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata)
	);

	est_slot_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// ===== rtl/est_chk.sv =====
// port checker for entity_slot_table, attached by the bind at the end
// depends on est_pkg
module est_chk
	import est_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               ok,
	input logic [SLOT_W-1:0]  slot_index,
	input logic [ID_BITS-1:0] given_id,
	input logic [CNT_W-1:0]   live_count
);

	// an accepted command keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// a result beat only closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result beat without a command in flight");

	// failed result carries no slot and no id
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ((slot_index == '0) && (given_id == '0)))
		else $error("failed result with nonzero slot or id");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (live_count <= CNT_W'(SLOTS)))
		else $error("live count above table size");

endmodule

bind entity_slot_table est_chk u_est_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.ok         (ok),
	.slot_index (slot_index),
	.given_id   (given_id),
	.live_count (live_count)
);
